### hw/rtl/sndva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sndva_pkg;

    localparam logic [8:0] FULL_VOLUME = 9'd256;
    localparam logic [3:0] MAX_VOICES_RESET = 4'd4;

    localparam logic CFG_MAX_VOICES     = 1'b0;
    localparam logic CFG_DEFAULT_VOLUME = 1'b1;

    localparam logic STAT_DONE       = 1'b0;
    localparam logic STAT_NOT_LOADED = 1'b1;

    typedef enum logic [2:0] {
        REQ_LOAD       = 3'd0,
        REQ_PLAY_DEF   = 3'd1,
        REQ_PLAY_VOL   = 3'd2,
        REQ_STOP_SOUND = 3'd3,
        REQ_STOP_ALL   = 3'd4,
        REQ_FINISHED   = 3'd5,
        REQ_CLEAR      = 3'd6
    } t_req_type;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_REUSE = 2'd1,
        KIND_NEW   = 2'd2,
        KIND_STEAL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PICK,
        S_COMMIT,
        S_SWEEP_RD,
        S_SWEEP_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_req_type  req_type;
        logic [3:0] sound_id;
        logic [2:0] slot;
        logic [8:0] volume;
    } t_request;

    typedef struct packed {
        logic       status;
        logic [2:0] voice_slot;
        t_kind      alloc_kind;
        logic [8:0] play_volume;
        logic [7:0] stopped_count;
    } t_result;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_valid;
        logic clr_valid;
    } t_mem_cmd;

    function automatic logic [8:0] sat_volume(input logic [8:0] v);
        return (v > FULL_VOLUME) ? FULL_VOLUME : v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sndva_pool_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module sndva_pool_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 23
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  sndva_pkg::t_mem_cmd  i_cmd,
    input  wire  [AW-1:0]        i_rd_addr,
    input  wire  [AW-1:0]        i_wr_addr,
    input  wire  [DW-1:0]        i_wr_data,
    output logic [DW-1:0]        o_rd_data,
    output logic                 o_rd_loaded
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_rd_data;
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_loaded;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // one valid bit per row doubles as the loaded flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_loaded <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_loaded <= r_valid[i_rd_addr];
            end
            if (i_cmd.clr_valid) begin
                r_valid <= '0;
            end else if (i_cmd.set_valid) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_loaded = r_rd_loaded;
    assign o_rd_data   = r_rd_loaded ? r_rd_data : '0;

endmodule

`default_nettype wire

### hw/rtl/sndva_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sndva_ctrl #(
    parameter int NUM_SOUNDS = 16,
    parameter int MAX_SLOTS  = 8,
    parameter int AW         = 4,
    parameter int DW         = 23
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    output logic                  o_req_ready,
    input  sndva_pkg::t_request   i_req,
    input  wire  [3:0]            i_max_voices,
    input  wire  [8:0]            i_default_volume,
    output logic                  o_res_valid,
    input  wire                   i_res_ready,
    output sndva_pkg::t_result    o_res,
    output sndva_pkg::t_mem_cmd   o_mem_cmd,
    output logic [AW-1:0]         o_rd_addr,
    output logic [AW-1:0]         o_wr_addr,
    output logic [DW-1:0]         o_wr_data,
    input  wire  [DW-1:0]         i_rd_data,
    input  wire                   i_rd_loaded
);

    localparam int SLW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int MS  = MAX_SLOTS;

    sndva_pkg::t_state    r_state, n_state;
    sndva_pkg::t_req_type r_req, n_req;
    sndva_pkg::t_kind     r_kind, n_kind;
    logic                 r_in_range, n_in_range;
    logic [AW-1:0]        r_addr, n_addr;
    logic [2:0]           r_slot, n_slot;
    logic [8:0]           r_vol, n_vol;
    logic [CW-1:0]        r_count, n_count;
    logic [SLW-1:0]       r_head, n_head;
    logic [MS-1:0]        r_play, n_play;
    logic [MS-1:0]        r_fin, n_fin;
    logic [CW-1:0]        r_i, n_i;
    logic [SLW-1:0]       r_p, n_p;
    logic [SLW-1:0]       r_vslot, n_vslot;
    logic                 r_status, n_status;
    logic [7:0]           r_stopped, n_stopped;
    logic [AW-1:0]        r_sweep, n_sweep;

    logic [8:0]     sid9;
    logic           in_range;
    logic [CW-1:0]  rd_count;
    logic [SLW-1:0] rd_head;
    logic [MS-1:0]  rd_play;
    logic [MS-1:0]  rd_fin;
    logic           known;
    logic [5:0]     slot6;
    logic           fin_hit;
    logic [MS-1:0]  slot_oh;
    logic [MS-1:0]  vslot_oh;
    logic [5:0]     limit;
    logic           scan_hit;
    logic           scan_last;
    logic [SLW-1:0] p_next;
    logic [SLW-1:0] head_next;
    logic           sweep_last;
    logic [8:0]     acc_sum;
    logic [5:0]     vslot6;

    assign sid9     = 9'(i_req.sound_id);
    assign in_range = sid9 < 9'(NUM_SOUNDS);

    assign rd_count = i_rd_data[CW-1:0];
    assign rd_head  = i_rd_data[CW +: SLW];
    assign rd_play  = i_rd_data[CW+SLW +: MS];
    assign rd_fin   = i_rd_data[CW+SLW+MS +: MS];
    assign known    = r_in_range & i_rd_loaded;

    assign slot6   = 6'(r_slot);
    assign slot_oh = MS'(1) << slot6[SLW-1:0];
    assign fin_hit = known && (slot6 < 6'(rd_count)) && (slot6 < 6'(MAX_SLOTS))
                     && rd_play[slot6[SLW-1:0]];

    assign limit = (i_max_voices == 4'd0) ? 6'd1 :
                   ((6'(i_max_voices) > 6'(MAX_SLOTS)) ? 6'(MAX_SLOTS) : 6'(i_max_voices));

    // ring walk: one logical voice per cycle
    assign scan_hit  = !r_play[r_p];
    assign scan_last = (r_i + CW'(1)) == r_count;
    assign p_next    = ((CW'(r_p) + CW'(1)) == r_count) ? '0 : r_p + SLW'(1);
    assign head_next = ((CW'(r_head) + CW'(1)) == r_count) ? '0 : r_head + SLW'(1);
    assign vslot_oh  = MS'(1) << r_vslot;

    assign sweep_last = r_sweep == AW'(NUM_SOUNDS - 1);
    assign acc_sum    = {1'b0, r_stopped} + 9'(rd_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sndva_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = sndva_pkg::S_DECODE;
                end
            end
            sndva_pkg::S_DECODE: begin
                case (r_req)
                    sndva_pkg::REQ_PLAY_DEF, sndva_pkg::REQ_PLAY_VOL: begin
                        if (!known) begin
                            n_state = sndva_pkg::S_DONE;
                        end else if (rd_count == '0) begin
                            n_state = sndva_pkg::S_PICK;
                        end else begin
                            n_state = sndva_pkg::S_SCAN;
                        end
                    end
                    sndva_pkg::REQ_STOP_ALL, sndva_pkg::REQ_CLEAR: begin
                        n_state = sndva_pkg::S_SWEEP_RD;
                    end
                    default: begin
                        n_state = sndva_pkg::S_DONE;
                    end
                endcase
            end
            sndva_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = sndva_pkg::S_COMMIT;
                end else if (scan_last) begin
                    n_state = sndva_pkg::S_PICK;
                end
            end
            sndva_pkg::S_PICK: begin
                n_state = sndva_pkg::S_COMMIT;
            end
            sndva_pkg::S_COMMIT: begin
                n_state = sndva_pkg::S_DONE;
            end
            sndva_pkg::S_SWEEP_RD: begin
                n_state = sndva_pkg::S_SWEEP_WR;
            end
            sndva_pkg::S_SWEEP_WR: begin
                n_state = sweep_last ? sndva_pkg::S_DONE : sndva_pkg::S_SWEEP_RD;
            end
            sndva_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = sndva_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sndva_pkg::S_IDLE;
            end
        endcase
    end

    // handshake and memory control
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_mem_cmd   = '0;
        o_rd_addr   = r_sweep;
        o_wr_addr   = r_addr;
        o_wr_data   = '0;
        case (r_state)
            sndva_pkg::S_IDLE: begin
                o_req_ready     = 1'b1;
                o_rd_addr       = sid9[AW-1:0];
                o_mem_cmd.rd_en = i_req_valid & in_range;
            end
            sndva_pkg::S_DECODE: begin
                case (r_req)
                    sndva_pkg::REQ_LOAD: begin
                        o_mem_cmd.wr_en     = r_in_range;
                        o_mem_cmd.set_valid = r_in_range;
                    end
                    sndva_pkg::REQ_STOP_SOUND: begin
                        o_mem_cmd.wr_en = known;
                        o_wr_data       = {{(2*MS){1'b0}}, rd_head, rd_count};
                    end
                    sndva_pkg::REQ_FINISHED: begin
                        o_mem_cmd.wr_en = fin_hit;
                        o_wr_data       = {rd_fin | slot_oh, rd_play, rd_head, rd_count};
                    end
                    default: begin
                        o_mem_cmd.wr_en = 1'b0;
                    end
                endcase
            end
            sndva_pkg::S_COMMIT: begin
                o_mem_cmd.wr_en = 1'b1;
                o_wr_data       = {r_fin & ~vslot_oh, r_play | vslot_oh, r_head, r_count};
            end
            sndva_pkg::S_SWEEP_RD: begin
                o_mem_cmd.rd_en = 1'b1;
            end
            sndva_pkg::S_SWEEP_WR: begin
                o_wr_addr           = r_sweep;
                o_mem_cmd.wr_en     = (r_req == sndva_pkg::REQ_STOP_ALL) & i_rd_loaded;
                o_wr_data           = {{(2*MS){1'b0}}, rd_head, rd_count};
                o_mem_cmd.clr_valid = (r_req == sndva_pkg::REQ_CLEAR) & sweep_last;
            end
            sndva_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_req      = r_req;
        n_kind     = r_kind;
        n_in_range = r_in_range;
        n_addr     = r_addr;
        n_slot     = r_slot;
        n_vol      = r_vol;
        n_count    = r_count;
        n_head     = r_head;
        n_play     = r_play;
        n_fin      = r_fin;
        n_i        = r_i;
        n_p        = r_p;
        n_vslot    = r_vslot;
        n_status   = r_status;
        n_stopped  = r_stopped;
        n_sweep    = r_sweep;
        case (r_state)
            sndva_pkg::S_IDLE: begin
                n_req      = i_req.req_type;
                n_in_range = in_range;
                n_addr     = sid9[AW-1:0];
                n_slot     = i_req.slot;
                n_vol      = (i_req.req_type == sndva_pkg::REQ_PLAY_DEF) ?
                             sndva_pkg::sat_volume(i_default_volume) :
                             sndva_pkg::sat_volume(i_req.volume);
                n_kind     = sndva_pkg::KIND_NONE;
                n_vslot    = '0;
                n_status   = sndva_pkg::STAT_DONE;
                n_stopped  = '0;
                n_sweep    = '0;
            end
            sndva_pkg::S_DECODE: begin
                case (r_req)
                    sndva_pkg::REQ_PLAY_DEF, sndva_pkg::REQ_PLAY_VOL: begin
                        if (!known) begin
                            n_status = sndva_pkg::STAT_NOT_LOADED;
                        end
                        // voices reported finished go back to stopped
                        n_count = rd_count;
                        n_head  = rd_head;
                        n_play  = rd_play & ~rd_fin;
                        n_fin   = rd_fin & ~rd_play;
                        n_p     = rd_head;
                        n_i     = '0;
                    end
                    sndva_pkg::REQ_STOP_SOUND: begin
                        if (!known) begin
                            n_status = sndva_pkg::STAT_NOT_LOADED;
                        end else begin
                            n_stopped = 8'(rd_count);
                        end
                    end
                    default: begin
                        n_status = r_status;
                    end
                endcase
            end
            sndva_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_vslot = r_p;
                    n_kind  = sndva_pkg::KIND_REUSE;
                end else begin
                    n_i = r_i + CW'(1);
                    n_p = p_next;
                end
            end
            sndva_pkg::S_PICK: begin
                if (6'(r_count) < limit) begin
                    n_vslot = SLW'(r_count);
                    n_count = r_count + CW'(1);
                    n_kind  = sndva_pkg::KIND_NEW;
                end else begin
                    n_vslot = r_head;
                    n_head  = head_next;
                    n_kind  = sndva_pkg::KIND_STEAL;
                end
            end
            sndva_pkg::S_SWEEP_WR: begin
                if (i_rd_loaded) begin
                    n_stopped = acc_sum[8] ? 8'hFF : acc_sum[7:0];
                end
                n_sweep = r_sweep + AW'(1);
            end
            default: begin
                n_sweep = r_sweep;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sndva_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_kind     <= n_kind;
        r_in_range <= n_in_range;
        r_addr     <= n_addr;
        r_slot     <= n_slot;
        r_vol      <= n_vol;
        r_count    <= n_count;
        r_head     <= n_head;
        r_play     <= n_play;
        r_fin      <= n_fin;
        r_i        <= n_i;
        r_p        <= n_p;
        r_vslot    <= n_vslot;
        r_status   <= n_status;
        r_stopped  <= n_stopped;
        r_sweep    <= n_sweep;
    end

    assign vslot6 = 6'(r_vslot);

    always_comb begin
        o_res.status        = r_status;
        o_res.voice_slot    = vslot6[2:0];
        o_res.alloc_kind    = r_kind;
        o_res.play_volume   = (r_kind != sndva_pkg::KIND_NONE) ? r_vol : 9'd0;
        o_res.stopped_count = r_stopped;
    end

endmodule

`default_nettype wire

### hw/rtl/sound_voice_allocator.sv
// play walks the ring of a loaded sound's voices, one slot per cycle, before its result
// stop all and clear sweep the pool memory row by row, read-modify-write for stop all
// load, stop sound, finished events and unknown codes need no walk or sweep; one request at a time
// reset clears the per-sound valid bits at once (no clearing pass); max_voices comes up as 4
//   and default_volume as 256
`timescale 1ns / 1ps
`default_nettype none

module sound_voice_allocator #(
    parameter int NUM_SOUNDS = 16,
    parameter int MAX_SLOTS  = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // sound_id[3:0], slot[6:4], volume[15:7]
    input  wire  [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[0], voice_slot[3:1], alloc_kind[5:4],
                                        // play_volume[14:6], stopped_count[22:15]
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [8:0]  i_cfg_wdata
);

    localparam int AW  = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int SLW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int DW  = CW + SLW + 2 * MAX_SLOTS;

    logic [3:0]          r_max_voices;
    logic [8:0]          r_default_volume;
    logic                r_out_valid;
    sndva_pkg::t_result  r_out;

    sndva_pkg::t_request req;
    sndva_pkg::t_result  res;
    sndva_pkg::t_mem_cmd mem_cmd;
    logic                res_valid;
    logic                res_ready;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [DW-1:0]       wr_data;
    logic [DW-1:0]       rd_data;
    logic                rd_loaded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_voices     <= sndva_pkg::MAX_VOICES_RESET;
            r_default_volume <= sndva_pkg::FULL_VOLUME;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sndva_pkg::CFG_MAX_VOICES) begin
                r_max_voices <= i_cfg_wdata[3:0];
            end else begin
                r_default_volume <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        req.req_type = sndva_pkg::t_req_type'(s_axis_tuser);
        req.sound_id = s_axis_tdata[3:0];
        req.slot     = s_axis_tdata[6:4];
        req.volume   = s_axis_tdata[15:7];
    end

    sndva_ctrl #(
        .NUM_SOUNDS (NUM_SOUNDS),
        .MAX_SLOTS  (MAX_SLOTS),
        .AW         (AW),
        .DW         (DW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (s_axis_tvalid),
        .o_req_ready      (s_axis_tready),
        .i_req            (req),
        .i_max_voices     (r_max_voices),
        .i_default_volume (r_default_volume),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res            (res),
        .o_mem_cmd        (mem_cmd),
        .o_rd_addr        (rd_addr),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .i_rd_data        (rd_data),
        .i_rd_loaded      (rd_loaded)
    );

    sndva_pool_mem #(
        .DEPTH (NUM_SOUNDS),
        .AW    (AW),
        .DW    (DW)
    ) u_pool_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (mem_cmd),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_data   (rd_data),
        .o_rd_loaded (rd_loaded)
    );

    // output register frees the engine while a result waits for its transfer
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.stopped_count, r_out.play_volume, r_out.alloc_kind,
                            r_out.voice_slot, r_out.status};

endmodule

`default_nettype wire
